// ===== rtl/jbtr_pkg.sv =====
// Shared types and constants for the JVM branch target resolver.
`timescale 1ns / 1ps
package jbtr_pkg;

  localparam int CODE_ADDR_BITS_DEF = 16;

  // bytes in a switch word and in a goto/jsr offset
  localparam int WORD_BYTES = 4;
  localparam int OFF_BYTES  = 2;

  localparam logic REQ_START = 1'b0;
  localparam logic REQ_BYTE  = 1'b1;

  localparam logic [1:0] KIND_GOTO   = 2'd0;
  localparam logic [1:0] KIND_JSR    = 2'd1;
  localparam logic [1:0] KIND_TABLE  = 2'd2;
  localparam logic [1:0] KIND_LOOKUP = 2'd3;

  typedef struct packed {
    logic               req_type;
    logic [1:0]         branch_kind;
    logic [15:0]        opcode_addr;
    logic signed [31:0] switch_key;
    logic [7:0]         code_byte;
  } jbtr_in_t;

  typedef struct packed {
    logic [15:0] target_pc;
    logic        push_return;
    logic [15:0] return_addr;
    logic        took_default;
    logic        bad_target;
  } jbtr_out_t;

endpackage

// ===== rtl/jbtr_stream_if.sv =====
// Valid/ready stream interface used by both channels.
`timescale 1ns / 1ps
interface jbtr_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/jvm_branch_target_resolver.sv =====
// JVM branch target resolver top level: goto, jsr, tableswitch, lookupswitch.
`timescale 1ns / 1ps
// A start transfer names the branch kind, opcode address and switch key; the
// code bytes after the opcode then follow one per transfer. The block takes one
// transfer every cycle: each byte is decoded by a single pass of compare and add
// logic that updates the parse state, and the target is written into the output
// register on the edge that accepts the deciding byte, so it is offered on the
// next cycle. Input is stalled only while that output register is full and not
// being drained. Bytes sent while no branch is open are dropped; a new start
// abandons any branch in progress.
module jvm_branch_target_resolver #(
  parameter int CODE_ADDR_BITS = jbtr_pkg::CODE_ADDR_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  jbtr_stream_if.sink         in_chan,
  jbtr_stream_if.source       out_chan
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_OFF16   = 4'd1;
  localparam logic [3:0] PH_PAD     = 4'd2;
  localparam logic [3:0] PH_DEFAULT = 4'd3;
  localparam logic [3:0] PH_LOW     = 4'd4;
  localparam logic [3:0] PH_HIGH    = 4'd5;
  localparam logic [3:0] PH_TABLE   = 4'd6;
  localparam logic [3:0] PH_COUNT   = 4'd7;
  localparam logic [3:0] PH_MATCH   = 4'd8;
  localparam logic [3:0] PH_PAIROFF = 4'd9;

  localparam int          MASK_BITS = (CODE_ADDR_BITS < 16) ? CODE_ADDR_BITS : 16;
  localparam logic [15:0] ADDR_MASK = 16'((17'h1 << MASK_BITS) - 17'h1);

  logic [3:0]  phase_r, phase_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [15:0] base_r, base_nxt;
  logic [31:0] key_r, key_nxt;
  logic [1:0]  pad_left_r, pad_left_nxt;
  logic [1:0]  byte_pos_r, byte_pos_nxt;
  logic [31:0] assemble_r, assemble_nxt;
  logic [31:0] default_r, default_nxt;
  logic [31:0] low_r, low_nxt;
  logic [31:0] high_cnt_r, high_cnt_nxt;
  logic [31:0] entry_r, entry_nxt;
  logic [31:0] match_r, match_nxt;

  logic                out_valid_r, out_valid_nxt;
  jbtr_pkg::jbtr_out_t out_data_r, out_data_nxt;

  jbtr_pkg::jbtr_in_t in_d;
  logic               acc;
  logic [31:0]        word;
  logic               last_byte;
  logic [31:0]        entry_inc;
  logic [15:0]        masked_addr;

  logic               emit;
  logic               emit_dflt;
  logic [31:0]        emit_off;
  logic signed [33:0] sum;
  logic               bad;

  assign in_d         = in_chan.data;
  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign acc          = in_chan.valid && in_chan.ready;
  assign word         = {assemble_r[23:0], in_d.code_byte};
  assign last_byte    = (phase_r == PH_OFF16) ? (byte_pos_r == 2'(jbtr_pkg::OFF_BYTES - 1))
                                              : (byte_pos_r == 2'(jbtr_pkg::WORD_BYTES - 1));
  assign entry_inc    = entry_r + 32'd1;
  assign masked_addr  = in_d.opcode_addr & ADDR_MASK;

  always_comb begin
    phase_nxt    = phase_r;
    kind_nxt     = kind_r;
    base_nxt     = base_r;
    key_nxt      = key_r;
    pad_left_nxt = pad_left_r;
    byte_pos_nxt = byte_pos_r;
    assemble_nxt = assemble_r;
    default_nxt  = default_r;
    low_nxt      = low_r;
    high_cnt_nxt = high_cnt_r;
    entry_nxt    = entry_r;
    match_nxt    = match_r;
    emit         = 1'b0;
    emit_dflt    = 1'b0;
    emit_off     = word;
    if (acc) begin
      if (in_d.req_type == jbtr_pkg::REQ_START) begin
        kind_nxt     = in_d.branch_kind;
        base_nxt     = masked_addr;
        key_nxt      = in_d.switch_key;
        byte_pos_nxt = 2'd0;
        assemble_nxt = 32'd0;
        entry_nxt    = 32'd0;
        match_nxt    = 32'd0;
        unique case (in_d.branch_kind) inside
          jbtr_pkg::KIND_GOTO, jbtr_pkg::KIND_JSR: begin
            phase_nxt = PH_OFF16;
          end
          jbtr_pkg::KIND_TABLE, jbtr_pkg::KIND_LOOKUP: begin
            // pad up to the next 4-byte boundary after the opcode
            pad_left_nxt = 2'd3 - masked_addr[1:0];
            phase_nxt    = (masked_addr[1:0] == 2'd3) ? PH_DEFAULT : PH_PAD;
          end
          default: begin
            phase_nxt = PH_OFF16;
          end
        endcase
      end else if (phase_r == PH_PAD) begin
        pad_left_nxt = pad_left_r - 2'd1;
        if (pad_left_r == 2'd1) begin
          phase_nxt = PH_DEFAULT;
        end
      end else if (phase_r != PH_IDLE) begin
        assemble_nxt = word;
        if (!last_byte) begin
          byte_pos_nxt = byte_pos_r + 2'd1;
        end else begin
          byte_pos_nxt = 2'd0;
          assemble_nxt = 32'd0;
          unique case (phase_r)
            PH_OFF16: begin
              emit     = 1'b1;
              emit_off = {{16{word[15]}}, word[15:0]};
            end
            PH_DEFAULT: begin
              default_nxt = word;
              phase_nxt   = (kind_r == jbtr_pkg::KIND_TABLE) ? PH_LOW : PH_COUNT;
            end
            PH_LOW: begin
              low_nxt   = word;
              phase_nxt = PH_HIGH;
            end
            PH_HIGH: begin
              high_cnt_nxt = word;
              if (($signed(key_r) < $signed(low_r)) || ($signed(key_r) > $signed(word))) begin
                emit      = 1'b1;
                emit_dflt = 1'b1;
              end else begin
                entry_nxt = key_r - low_r;
                phase_nxt = PH_TABLE;
              end
            end
            PH_TABLE: begin
              if (entry_r == 32'd0) begin
                emit = 1'b1;
              end else begin
                entry_nxt = entry_r - 32'd1;
              end
            end
            PH_COUNT: begin
              high_cnt_nxt = word;
              entry_nxt    = 32'd0;
              if ($signed(word) <= 0) begin
                emit      = 1'b1;
                emit_dflt = 1'b1;
              end else begin
                phase_nxt = PH_MATCH;
              end
            end
            PH_MATCH: begin
              match_nxt = word;
              phase_nxt = PH_PAIROFF;
            end
            PH_PAIROFF: begin
              if (key_r == match_r) begin
                emit = 1'b1;
              end else begin
                entry_nxt = entry_inc;
                if (entry_inc >= high_cnt_r) begin
                  emit      = 1'b1;
                  emit_dflt = 1'b1;
                end else begin
                  phase_nxt = PH_MATCH;
                end
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
          if (emit_dflt) begin
            emit_off = default_r;
          end
          if (emit) begin
            phase_nxt = PH_IDLE;
          end
        end
      end
    end
  end

  // target = base + signed offset, range checked against the code size
  assign sum = $signed({18'd0, base_r}) + $signed({{2{emit_off[31]}}, emit_off});
  assign bad = sum[33] || (|(sum[32:0] >> CODE_ADDR_BITS));

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (acc && emit) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.target_pc    = sum[15:0];
      out_data_nxt.push_return  = (kind_r == jbtr_pkg::KIND_JSR);
      out_data_nxt.return_addr  = (kind_r == jbtr_pkg::KIND_JSR) ?
                                  ((base_r + 16'd3) & ADDR_MASK) : 16'd0;
      out_data_nxt.took_default = emit_dflt;
      out_data_nxt.bad_target   = bad;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    base_r     <= base_nxt;
    key_r      <= key_nxt;
    pad_left_r <= pad_left_nxt;
    byte_pos_r <= byte_pos_nxt;
    assemble_r <= assemble_nxt;
    default_r  <= default_nxt;
    low_r      <= low_nxt;
    high_cnt_r <= high_cnt_nxt;
    entry_r    <= entry_nxt;
    match_r    <= match_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_data_r;

  a_out_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(acc))
    else $error("result appeared without an input transfer");

  a_idle_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && emit) |=> (phase_r == PH_IDLE))
    else $error("parser not idle after target emitted");

  a_pad_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_PAD) |-> (pad_left_r != 2'd0))
    else $error("padding phase with no bytes left");

  a_default_not_jsr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.took_default) |-> !out_data_r.push_return)
    else $error("default taken on a jsr");

endmodule

// ===== sim/tb_jvm_branch_target_resolver.sv =====
// Self-checking testbench for the JVM branch target resolver.
`timescale 1ns / 1ps
module tb_jvm_branch_target_resolver;

  localparam int HALF_PERIOD  = 10;
  localparam int RESET_CYCLES = 7;
  localparam int ADDR_BITS    = jbtr_pkg::CODE_ADDR_BITS_DEF;
  localparam longint ADDR_MASK = (longint'(1) << ADDR_BITS) - 1;
  localparam int RANDOM_ITEMS = 1650;
  localparam int QUIET_ITEMS  = 150;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int CYCLE_LIMIT  = 250000;

  typedef enum logic [3:0] {
    P_IDLE, P_OFF16, P_PAD, P_DEFAULT, P_LOW, P_HIGH, P_TABLE, P_COUNT, P_MATCH, P_PAIROFF
  } parse_phase_t;

  typedef struct {
    jbtr_pkg::jbtr_in_t  item;
    bit                  pinned;
    jbtr_pkg::jbtr_out_t want;
  } plan_row_t;

  logic clk;
  logic rst_n;

  jbtr_stream_if #(.T(jbtr_pkg::jbtr_in_t))  in_if ();
  jbtr_stream_if #(.T(jbtr_pkg::jbtr_out_t)) out_if ();

  jvm_branch_target_resolver #(.CODE_ADDR_BITS(ADDR_BITS)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  // parser state mirrored from the block
  parse_phase_t prs_phase = P_IDLE;
  logic [1:0]   prs_kind  = '0;
  logic [15:0]  prs_base  = '0;
  logic [31:0]  prs_key   = '0;
  logic [1:0]   prs_pad   = '0;
  logic [1:0]   prs_pos   = '0;
  logic [31:0]  prs_acc   = '0;
  logic [31:0]  prs_dflt  = '0;
  logic [31:0]  prs_low   = '0;
  logic [31:0]  prs_cnt   = '0;
  logic [31:0]  prs_idx   = '0;
  logic [31:0]  prs_match = '0;

  jbtr_pkg::jbtr_out_t pending_targets[$];
  plan_row_t           plan_q[$];

  // hand-written expectation riding along with the current transfer
  logic                pin_has;
  jbtr_pkg::jbtr_out_t pin_want;

  bit gap_on     = 1'b1;
  bit quiet      = 1'b0;
  bit hold_armed = 1'b0;
  bit hold_done  = 1'b0;

  int errors    = 0;
  int n_checked = 0;
  int n_default = 0;
  int n_bad     = 0;
  int kind_cnt[4] = '{0, 0, 0, 0};
  int cycle_cnt;
  int hold_cnt;
  int rnd_sent  = 0;

  initial clk = 1'b0;
  always begin
    #HALF_PERIOD clk = ~clk;
  end

  function automatic jbtr_pkg::jbtr_out_t make_target(longint off, bit dflt);
    jbtr_pkg::jbtr_out_t r;
    longint              sum;
    sum            = longint'(prs_base) + off;
    r.target_pc    = sum[15:0];
    r.push_return  = (prs_kind == jbtr_pkg::KIND_JSR);
    r.return_addr  = r.push_return ? 16'((longint'(prs_base) + 3) & ADDR_MASK) : 16'h0000;
    r.took_default = dflt;
    r.bad_target   = (sum < 0) || (sum > ADDR_MASK);
    return r;
  endfunction

  task automatic advance_parser(input jbtr_pkg::jbtr_in_t it, output bit hit,
                                output jbtr_pkg::jbtr_out_t res);
    logic [31:0] word;
    int          need;
    hit = 1'b0;
    res = '0;
    if (it.req_type == jbtr_pkg::REQ_START) begin
      prs_kind  = it.branch_kind;
      prs_base  = 16'(longint'(it.opcode_addr) & ADDR_MASK);
      prs_key   = it.switch_key;
      prs_pos   = '0;
      prs_acc   = '0;
      prs_idx   = '0;
      prs_match = '0;
      if (prs_kind == jbtr_pkg::KIND_GOTO || prs_kind == jbtr_pkg::KIND_JSR) begin
        prs_phase = P_OFF16;
      end else begin
        prs_pad   = 2'(3 - prs_base[1:0]);
        prs_phase = (prs_pad != 2'd0) ? P_PAD : P_DEFAULT;
      end
      return;
    end
    if (prs_phase == P_IDLE) return;
    if (prs_phase == P_PAD) begin
      prs_pad = prs_pad - 2'd1;
      if (prs_pad == 2'd0) prs_phase = P_DEFAULT;
      return;
    end
    prs_acc = {prs_acc[23:0], it.code_byte};
    need    = (prs_phase == P_OFF16) ? jbtr_pkg::OFF_BYTES : jbtr_pkg::WORD_BYTES;
    if (int'(prs_pos) + 1 < need) begin
      prs_pos = prs_pos + 2'd1;
      return;
    end
    prs_pos = '0;
    word    = prs_acc;
    prs_acc = '0;
    case (prs_phase)
      P_OFF16: begin
        res = make_target(longint'($signed(word[15:0])), 1'b0);
        hit = 1'b1;
      end
      P_DEFAULT: begin
        prs_dflt  = word;
        prs_phase = (prs_kind == jbtr_pkg::KIND_TABLE) ? P_LOW : P_COUNT;
      end
      P_LOW: begin
        prs_low   = word;
        prs_phase = P_HIGH;
      end
      P_HIGH: begin
        prs_cnt = word;
        if ($signed(prs_key) < $signed(prs_low) || $signed(prs_key) > $signed(prs_cnt)) begin
          res = make_target(longint'($signed(prs_dflt)), 1'b1);
          hit = 1'b1;
        end else begin
          prs_idx   = prs_key - prs_low;
          prs_phase = P_TABLE;
        end
      end
      P_TABLE: begin
        if (prs_idx == 32'd0) begin
          res = make_target(longint'($signed(word)), 1'b0);
          hit = 1'b1;
        end else begin
          prs_idx = prs_idx - 32'd1;
        end
      end
      P_COUNT: begin
        prs_cnt = word;
        if ($signed(word) <= 0) begin
          res = make_target(longint'($signed(prs_dflt)), 1'b1);
          hit = 1'b1;
        end else begin
          prs_idx   = '0;
          prs_phase = P_MATCH;
        end
      end
      P_MATCH: begin
        prs_match = word;
        prs_phase = P_PAIROFF;
      end
      P_PAIROFF: begin
        if (prs_key == prs_match) begin
          res = make_target(longint'($signed(word)), 1'b0);
          hit = 1'b1;
        end else begin
          prs_idx = prs_idx + 32'd1;
          if (prs_idx >= prs_cnt) begin
            res = make_target(longint'($signed(prs_dflt)), 1'b1);
            hit = 1'b1;
          end else begin
            prs_phase = P_MATCH;
          end
        end
      end
      default: prs_phase = P_IDLE;
    endcase
    if (hit) prs_phase = P_IDLE;
  endtask

  task automatic cmp_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endtask

  // results are checked before the same edge's input is predicted
  always @(posedge clk) begin : scoreboard
    jbtr_pkg::jbtr_out_t want;
    jbtr_pkg::jbtr_out_t got;
    jbtr_pkg::jbtr_out_t res;
    bit                  hit;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got = out_if.data;
        if (pending_targets.size() == 0) begin
          errors++;
          $display("%0t: unexpected result, expected none, actual target_pc 0x%0h",
                   $time, got.target_pc);
        end else begin
          want = pending_targets.pop_front();
          n_checked++;
          cmp_field("target_pc", want.target_pc, got.target_pc);
          cmp_field("push_return", want.push_return, got.push_return);
          cmp_field("return_addr", want.return_addr, got.return_addr);
          cmp_field("took_default", want.took_default, got.took_default);
          cmp_field("bad_target", want.bad_target, got.bad_target);
        end
      end
      if (in_if.valid && in_if.ready) begin
        if (in_if.data.req_type == jbtr_pkg::REQ_START) kind_cnt[in_if.data.branch_kind]++;
        advance_parser(in_if.data, hit, res);
        if (pin_has) res = pin_want;
        if (hit || pin_has) begin
          pending_targets.push_back(res);
          if (res.took_default) n_default++;
          if (res.bad_target) n_bad++;
        end
      end
    end
  end

  // receiver: random stalls, one long hold-off, always ready near the end
  initial begin
    out_if.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_armed && !hold_done) begin
        out_if.ready <= 1'b0;
        for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge clk);
        hold_done = 1'b1;
      end else if (quiet || $urandom_range(0, 3) != 0) begin
        out_if.ready <= 1'b1;
        repeat (quiet ? 1 : $urandom_range(1, 24)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end
    end
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("Timeout after %0d cycles, %0d targets still pending", cycle_cnt,
             pending_targets.size());
    $display("jvm_branch_target_resolver verification failed");
    $finish;
  end

  task automatic put_row(jbtr_pkg::jbtr_in_t it);
    plan_row_t r;
    r.item   = it;
    r.pinned = 1'b0;
    r.want   = '0;
    plan_q.push_back(r);
  endtask

  task automatic put_start(logic [1:0] kind, logic [15:0] addr, logic [31:0] key);
    jbtr_pkg::jbtr_in_t it;
    it.req_type    = jbtr_pkg::REQ_START;
    it.branch_kind = kind;
    it.opcode_addr = addr;
    it.switch_key  = key;
    it.code_byte   = 8'($urandom);
    put_row(it);
  endtask

  // fields other than code_byte carry junk on byte transfers
  task automatic put_byte(logic [7:0] b);
    jbtr_pkg::jbtr_in_t it;
    it.req_type    = jbtr_pkg::REQ_BYTE;
    it.branch_kind = 2'($urandom);
    it.opcode_addr = 16'($urandom);
    it.switch_key  = $urandom;
    it.code_byte   = b;
    put_row(it);
  endtask

  task automatic put_word(logic [31:0] w);
    put_byte(w[31:24]);
    put_byte(w[23:16]);
    put_byte(w[15:8]);
    put_byte(w[7:0]);
  endtask

  task automatic pin_last(jbtr_pkg::jbtr_out_t want);
    plan_q[$].pinned = 1'b1;
    plan_q[$].want   = want;
  endtask

  function automatic logic [31:0] pick_off32();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return $urandom;
      default: return 32'($urandom_range(0, 600)) - 32'd300;
    endcase
  endfunction

  // one complete branch: start, padding, words up to the deciding byte
  task automatic plan_branch(output int n_items);
    logic [1:0]  kind;
    logic [15:0] addr;
    logic [31:0] key;
    logic [31:0] low;
    logic [31:0] high;
    logic [31:0] w;
    int          span;
    int          idx;
    int          np;
    int          hit_at;
    int          i;
    kind = 2'($urandom);
    case ($urandom_range(0, 9))
      0:       addr = 16'h0000;
      1:       addr = 16'hFFFF;
      default: addr = 16'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       key = 32'h8000_0000;
      1:       key = 32'h7FFF_FFFF;
      default: key = $urandom;
    endcase
    put_start(kind, addr, key);
    if (kind == jbtr_pkg::KIND_GOTO || kind == jbtr_pkg::KIND_JSR) begin
      case ($urandom_range(0, 7))
        0:       w = 32'h7FFF;
        1:       w = 32'h8000;
        2:       w = 32'hFFFF;
        3:       w = 32'h0000;
        default: w = 32'($urandom_range(0, 65535));
      endcase
      put_byte(w[15:8]);
      put_byte(w[7:0]);
    end else begin
      repeat (int'(2'(3 - addr[1:0]))) put_byte(8'($urandom));
      put_word(pick_off32());
      if (kind == jbtr_pkg::KIND_TABLE) begin
        span = $urandom_range(0, 7);
        case ($urandom_range(0, 4))
          0: begin
            low  = 32'h8000_0000;
            high = low + 32'(span);
          end
          1: begin
            low  = 32'h7FFF_FFFF - 32'(span);
            high = 32'h7FFF_FFFF;
          end
          2: begin
            // inverted bounds: every key misses
            low  = 32'($urandom_range(0, 1000));
            high = low - 32'd1 - 32'($urandom_range(0, 1000));
          end
          default: begin
            low  = 32'($urandom_range(0, 2000)) - 32'd1000;
            high = low + 32'(span);
          end
        endcase
        if ($urandom_range(0, 3) != 0) key = low + 32'($urandom_range(0, span));
        plan_q[0].item.switch_key = key;
        put_word(low);
        put_word(high);
        if (!($signed(key) < $signed(low) || $signed(key) > $signed(high))) begin
          idx = int'(key - low);
          for (i = 0; i <= idx; i++) put_word(pick_off32());
        end
      end else begin
        if ($urandom_range(0, 7) == 0)
          w = $urandom_range(0, 1) ? 32'h0 : ($urandom | 32'h8000_0000);
        else
          w = 32'($urandom_range(1, 6));
        put_word(w);
        if ($signed(w) > 0) begin
          np     = int'(w);
          hit_at = ($urandom_range(0, 9) < 7) ? $urandom_range(0, np - 1) : np;
          for (i = 0; i < np && i <= hit_at; i++) begin
            if (i == hit_at) begin
              put_word(key);
            end else begin
              w = $urandom;
              if (w == key) w = ~key;
              put_word(w);
            end
            put_word(pick_off32());
          end
        end
      end
    end
    n_items = plan_q.size();
  endtask

  task automatic send_item(input plan_row_t r);
    if (gap_on && !quiet && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= r.item;
    pin_has     <= r.pinned;
    pin_want    <= r.want;
    do @(posedge clk); while (!in_if.ready);
  endtask

  task automatic run_plan();
    while (plan_q.size() > 0) send_item(plan_q.pop_front());
  endtask

  initial begin : stimulus
    jbtr_pkg::jbtr_in_t idle_byte;
    int                 n;
    int                 keep;
    rst_n       <= 1'b0;
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    pin_has     <= 1'b0;
    pin_want    <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // byte with no branch open, all ignored fields at their ones extreme
    idle_byte = '{jbtr_pkg::REQ_BYTE, jbtr_pkg::KIND_LOOKUP, 16'hFFFF, 32'hFFFF_FFFF, 8'hFF};
    put_row(idle_byte);
    put_start(jbtr_pkg::KIND_GOTO, 16'h0010, 32'h7FFF_FFFF);
    put_byte(8'h00);
    put_byte(8'h05);
    pin_last('{16'h0015, 1'b0, 16'h0000, 1'b0, 1'b0});
    // jsr past the top of code space; return address wraps
    put_start(jbtr_pkg::KIND_JSR, 16'hFFFE, 32'h8000_0000);
    put_byte(8'h7F);
    put_byte(8'hFF);
    pin_last('{16'h7FFD, 1'b1, 16'h0001, 1'b0, 1'b1});
    // jsr abandoned mid-offset by a new start; goto below address zero
    put_start(jbtr_pkg::KIND_JSR, 16'h1234, 32'h0);
    put_byte(8'h12);
    put_start(jbtr_pkg::KIND_GOTO, 16'h0000, 32'h0);
    put_byte(8'h80);
    put_byte(8'h00);
    pin_last('{16'h8000, 1'b0, 16'h0000, 1'b0, 1'b1});
    // aligned tableswitch, low above high
    put_start(jbtr_pkg::KIND_TABLE, 16'h0003, 32'h0);
    put_word(32'h0000_0020);
    put_word(32'h0000_0001);
    put_word(32'h0000_0000);
    pin_last('{16'h0023, 1'b0, 16'h0000, 1'b1, 1'b0});
    // tableswitch abandoned inside padding
    put_start(jbtr_pkg::KIND_TABLE, 16'h0001, 32'h0);
    put_byte(8'hAA);
    // lookupswitch, three pad bytes, no pairs, negative default
    put_start(jbtr_pkg::KIND_LOOKUP, 16'h0000, 32'h5);
    repeat (3) put_byte(8'h00);
    put_word(32'hFFFF_FFFC);
    put_word(32'h0000_0000);
    pin_last('{16'hFFFC, 1'b0, 16'h0000, 1'b1, 1'b1});
    run_plan();

    hold_armed = 1'b1;
    while (rnd_sent < RANDOM_ITEMS) begin
      quiet  = (rnd_sent >= RANDOM_ITEMS - QUIET_ITEMS);
      gap_on = ($urandom_range(0, 3) != 0);
      plan_branch(n);
      if ($urandom_range(0, 9) == 0) begin
        // cut short; the next start drops it
        keep = $urandom_range(1, n - 1);
        while (plan_q.size() > keep) void'(plan_q.pop_back());
        n = keep;
      end else if ($urandom_range(0, 11) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom));
      end
      rnd_sent += n;
      run_plan();
    end
    in_if.valid <= 1'b0;

    while (pending_targets.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Covered %0d goto, %0d jsr, %0d tableswitch, %0d lookupswitch starts",
             kind_cnt[jbtr_pkg::KIND_GOTO], kind_cnt[jbtr_pkg::KIND_JSR],
             kind_cnt[jbtr_pkg::KIND_TABLE], kind_cnt[jbtr_pkg::KIND_LOOKUP]);
    $display("%0d targets checked: %0d via default, %0d outside code range; %0d errors",
             n_checked, n_default, n_bad, errors);
    if (errors == 0 && pending_targets.size() == 0) begin
      $display("jvm_branch_target_resolver verification clean");
    end else begin
      $display("jvm_branch_target_resolver verification failed");
    end
    $finish;
  end

endmodule
